// ===== rtl/elevator_sweep_scheduler_assert.svh =====
// assertion macros for the elevator sweep scheduler
`ifndef ELEVATOR_SWEEP_SCHEDULER_ASSERT_SVH
`define ELEVATOR_SWEEP_SCHEDULER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ESS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ESS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ESS_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define ESS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ESS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/ess_pkg.sv =====
// shared codes and constants of the elevator sweep scheduler
package ess_pkg;

	localparam logic [1:0] OP_CALL = 2'd0;
	localparam logic [1:0] OP_DEST = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic REG_FLOOR_COUNT = 1'b0;
	localparam logic REG_CAPACITY    = 1'b1;

	localparam logic [4:0] FLOOR_COUNT_RST = 5'd16;
	localparam logic [7:0] CAPACITY_RST    = 8'd8;

	localparam int IN_DATA_W  = 8;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 32;

endpackage

// ===== rtl/ess_ram.sv =====
// generic single-write, single-read ram with registered read data
module ess_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/elevator_sweep_scheduler.sv =====
// elevator sweep scheduler top level
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser opcode, tdata floor
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata tick result
//  cfg       in   cfg_we                          cfg_index, cfg_data
//
// one beat is taken every cycle unless stalled; a tick result reaches the output
// register from the work stage; per-floor counts live in a ram with registered read,
// a bypass register covers a write that lands on the edge of the next read
// reset clears the entry valid bits at once, so no clearing pass is needed
// input stalls only while a tick sits in the work stage and the output
// register holds a result that is not taken
`include "elevator_sweep_scheduler_assert.svh"

module elevator_sweep_scheduler #(
	parameter int MAX_FLOORS = 16,
	parameter int COUNT_MAX  = 255
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [3:0] floor, [7:4] zero
	input  logic [ess_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] opcode
	input  logic [ess_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [3:0] visited_floor, [11:4] unloaded, [19:12] boarded,
	// [27:20] load_after, [28] heading_up, [31:29] zero
	output logic [ess_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [7:0]                     cfg_data
);

	import ess_pkg::*;

	localparam int FW = $clog2(MAX_FLOORS);
	localparam int CW = $clog2(COUNT_MAX + 1);
	localparam int NW = ($clog2(MAX_FLOORS + 1) > 5) ? $clog2(MAX_FLOORS + 1) : 5;
	localparam int UW = (CW > 8) ? CW : 8;

	// configuration
	logic [4:0] floor_count_q;
	logic [7:0] capacity_q;

	// sweep position, advanced when a tick beat is taken
	logic [FW-1:0] cur_q;
	logic          up_q;
	logic [7:0]    load_q;

	// work stage
	logic          valid_s1;
	logic [1:0]    op_s1;
	logic [FW-1:0] addr_s1;
	logic          hit_s1;
	logic          up_s1;

	// output register
	logic       out_valid_q;
	logic [3:0] out_floor_q;
	logic [7:0] out_unl_q;
	logic [7:0] out_brd_q;
	logic [7:0] out_load_q;
	logic       out_up_q;

	// entry valid bits and write bypass
	logic [MAX_FLOORS-1:0] vld_q;
	logic                  byp_valid_q;
	logic [FW-1:0]         byp_addr_q;
	logic [2*CW-1:0]       byp_data_q;

	logic            in_acc;
	logic            s1_go;
	logic [1:0]      in_op;
	logic [NW-1:0]   fc_w;
	logic [NW-1:0]   n_w;
	logic [FW-1:0]   top_w;
	logic [FW+3:0]   fl_wide;
	logic [FW-1:0]   fl_addr;
	logic            fl_hit;
	logic [FW:0]     cur_p1;
	logic [FW-1:0]   cur_m1;
	logic [FW-1:0]   nxt_floor;
	logic            nxt_up;
	logic [FW-1:0]   rd_addr;
	logic [2*CW-1:0] rdata;
	logic [2*CW-1:0] ent;
	logic [CW-1:0]   waiting;
	logic [CW-1:0]   bound;
	logic [CW-1:0]   wait_n;
	logic [CW-1:0]   bound_n;
	logic            wr_en;
	logic [UW-1:0]   unl_w;
	logic [UW-1:0]   ld_w;
	logic [UW-1:0]   ld1_w;
	logic [7:0]      ld1;
	logic [7:0]      room;
	logic [UW-1:0]   wait_w;
	logic [UW-1:0]   brd_w;
	logic [7:0]      load_nxt;
	logic [FW+3:0]   vis_wide;

	assign in_op  = s_axis_tuser[1:0];
	assign s1_go  = valid_s1 && (op_s1 != OP_TICK || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_go;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// effective floor count and top floor
	assign fc_w  = NW'(floor_count_q);
	assign n_w   = (fc_w < NW'(2)) ? NW'(2) :
		((fc_w > NW'(MAX_FLOORS)) ? NW'(MAX_FLOORS) : fc_w);
	assign top_w = FW'(n_w - NW'(1));

	assign fl_wide = (FW + 4)'(s_axis_tdata[3:0]);
	assign fl_addr = fl_wide[FW-1:0];
	assign fl_hit  = NW'(s_axis_tdata[3:0]) < n_w;

	// next position of the sweep
	assign cur_p1 = {1'b0, cur_q} + (FW + 1)'(1);
	assign cur_m1 = cur_q - FW'(1);

	always_comb begin
		nxt_floor = cur_q;
		nxt_up    = up_q;
		if (up_q) begin
			if (cur_p1 >= {1'b0, top_w}) begin
				nxt_floor = top_w;
				nxt_up    = 1'b0;
			end else begin
				nxt_floor = cur_p1[FW-1:0];
			end
		end else if (cur_q == '0) begin
			nxt_floor = FW'(1);
			nxt_up    = 1'b1;
		end else begin
			nxt_floor = (cur_m1 > top_w) ? top_w : cur_m1;
		end
	end

	assign rd_addr = (in_op == OP_TICK) ? cur_q : fl_addr;

	ess_ram #(
		.WIDTH (2 * CW),
		.DEPTH (MAX_FLOORS)
	) u_count_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata ({bound_n, wait_n}),
		.re    (in_acc),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// current counts of the floor in the work stage
	always_comb begin
		if (byp_valid_q && byp_addr_q == addr_s1) begin
			ent = byp_data_q;
		end else if (vld_q[addr_s1]) begin
			ent = rdata;
		end else begin
			ent = '0;
		end
	end
	assign waiting = ent[CW-1:0];
	assign bound   = ent[2*CW-1:CW];

	// unload, then board up to the room left
	assign unl_w  = UW'(bound);
	assign ld_w   = UW'(load_q);
	assign ld1_w  = (ld_w > unl_w) ? ld_w - unl_w : '0;
	assign ld1    = ld1_w[7:0];
	assign room   = (capacity_q > ld1) ? capacity_q - ld1 : 8'd0;
	assign wait_w = UW'(waiting);
	assign brd_w  = (wait_w < UW'(room)) ? wait_w : UW'(room);
	assign load_nxt = ld1 + brd_w[7:0];

	always_comb begin
		wait_n  = waiting;
		bound_n = bound;
		wr_en   = 1'b0;
		case (op_s1)
			OP_CALL: begin
				if (waiting < CW'(COUNT_MAX)) wait_n = waiting + CW'(1);
				wr_en = s1_go && hit_s1;
			end
			OP_DEST: begin
				if (bound < CW'(COUNT_MAX)) bound_n = bound + CW'(1);
				wr_en = s1_go && hit_s1;
			end
			OP_TICK: begin
				wait_n  = waiting - CW'(brd_w);
				bound_n = '0;
				wr_en   = s1_go;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign vis_wide = (FW + 4)'(addr_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_count_q <= FLOOR_COUNT_RST;
			capacity_q    <= CAPACITY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FLOOR_COUNT: floor_count_q <= cfg_data[4:0];
				REG_CAPACITY:    capacity_q    <= cfg_data;
				default:         capacity_q    <= capacity_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			up_q        <= 1'b1;
			load_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			byp_valid_q <= 1'b0;
		end else begin
			if (in_acc && in_op == OP_TICK) begin
				cur_q <= nxt_floor;
				up_q  <= nxt_up;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go && op_s1 == OP_TICK) begin
				load_q      <= load_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				vld_q[addr_s1] <= 1'b1;
				byp_valid_q    <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= in_op;
			addr_s1 <= rd_addr;
			hit_s1  <= fl_hit;
			up_s1   <= (in_op == OP_TICK) ? nxt_up : up_q;
		end
		if (wr_en) begin
			byp_addr_q <= addr_s1;
			byp_data_q <= {bound_n, wait_n};
		end
		if (s1_go && op_s1 == OP_TICK) begin
			out_floor_q <= vis_wide[3:0];
			out_unl_q   <= unl_w[7:0];
			out_brd_q   <= brd_w[7:0];
			out_load_q  <= load_nxt;
			out_up_q    <= up_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_up_q, out_load_q, out_brd_q, out_unl_q, out_floor_q};

	`ESS_ASSERT(a_result_from_tick, clk, arst_n, $rose(out_valid_q) |-> $past(valid_s1 && op_s1 == OP_TICK), "result without a tick in the work stage")
	`ESS_ASSERT(a_boarded_in_load, clk, arst_n, out_valid_q |-> (out_load_q >= out_brd_q), "boarded count exceeds load")
	`ESS_ASSERT(a_stall_cause, clk, arst_n, !s_axis_tready |-> (valid_s1 && op_s1 == OP_TICK && out_valid_q && !m_axis_tready), "input stalled without a blocked tick")
	`ESS_ASSERT_NEVER(a_no_write_idle, clk, arst_n, wr_en && !valid_s1, "count write with empty work stage")

endmodule

// ===== sim/elevator_sweep_scheduler_test.sv =====
// self-checking testbench for the elevator sweep scheduler, predicting every tick result
module elevator_sweep_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ess_pkg::*;

	localparam int MAX_FLOORS = 16;
	localparam int COUNT_MAX  = 255;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BEATS = 240;
	// opcode with no meaning, dropped by the block
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [3:0] lvl;
		logic [7:0] unloaded;
		logic [7:0] boarded;
		logic [7:0] load_after;
		logic       heading_up;
	} stop_t;

	class sweep_scoreboard;
		logic [7:0] waiting[MAX_FLOORS];
		logic [7:0] bound[MAX_FLOORS];
		logic [3:0] floor_now;
		logic       going_up;
		logic [7:0] load;
		logic [4:0] floor_reg;
		logic [7:0] cap_reg;
		stop_t      pending_stops[$];
		int         failures;
		int         stops_checked;

		function new();
			for (int i = 0; i < MAX_FLOORS; i++) begin
				waiting[i] = '0;
				bound[i] = '0;
			end
			floor_now = '0;
			going_up = 1'b1;
			load = '0;
			floor_reg = FLOOR_COUNT_RST;
			cap_reg = CAPACITY_RST;
			failures = 0;
			stops_checked = 0;
		endfunction

		function int active_floors();
			int n;
			n = floor_reg;
			if (n < 2) n = 2;
			if (n > MAX_FLOORS) n = MAX_FLOORS;
			return n;
		endfunction

		function void set_reg(logic idx, logic [7:0] val);
			if (idx == REG_FLOOR_COUNT) floor_reg = val[4:0];
			else cap_reg = val;
		endfunction

		// advance the lift model by one accepted request beat
		function void note_request(logic [1:0] op, logic [3:0] fl);
			int n, top, cur, unl, room, brd, nx;
			stop_t s;
			n = active_floors();
			top = n - 1;
			if (op == OP_CALL || op == OP_DEST) begin
				if (fl < n) begin
					if (op == OP_CALL) begin
						if (waiting[fl] < COUNT_MAX) waiting[fl] = waiting[fl] + 8'd1;
					end else begin
						if (bound[fl] < COUNT_MAX) bound[fl] = bound[fl] + 8'd1;
					end
				end
				return;
			end
			if (op != OP_TICK) return;
			cur = floor_now;
			unl = bound[cur];
			bound[cur] = '0;
			load = (load > unl) ? 8'(load - unl) : 8'd0;
			room = (cap_reg > load) ? cap_reg - load : 0;
			brd = (waiting[cur] < room) ? waiting[cur] : room;
			waiting[cur] = 8'(waiting[cur] - brd);
			load = 8'(load + brd);
			if (going_up) begin
				nx = cur + 1;
				if (nx >= top) begin
					nx = top;
					going_up = 1'b0;
				end
				floor_now = 4'(nx);
			end else if (cur == 0) begin
				floor_now = 4'd1;
				going_up = 1'b1;
			end else begin
				// lift stranded above a lowered top floor drops straight to it
				nx = cur - 1;
				if (nx > top) nx = top;
				floor_now = 4'(nx);
			end
			s.lvl = 4'(cur);
			s.unloaded = 8'(unl);
			s.boarded = 8'(brd);
			s.load_after = load;
			s.heading_up = going_up;
			pending_stops.push_back(s);
		endfunction

		function void report(string what, stop_t want, stop_t got);
			failures++;
			if (failures <= 10)
				$display("%s: expected floor %0d unl %0d brd %0d load %0d up %0b, got floor %0d unl %0d brd %0d load %0d up %0b",
					what, want.lvl, want.unloaded, want.boarded, want.load_after,
					want.heading_up, got.lvl, got.unloaded, got.boarded, got.load_after,
					got.heading_up);
		endfunction

		function void check_stop(logic [OUT_DATA_W-1:0] beat);
			stop_t got, want;
			got.lvl = beat[3:0];
			got.unloaded = beat[11:4];
			got.boarded = beat[19:12];
			got.load_after = beat[27:20];
			got.heading_up = beat[28];
			stops_checked++;
			if (pending_stops.size() == 0) begin
				want = '{default: '0};
				report("stop with no tick pending", want, got);
				return;
			end
			want = pending_stops.pop_front();
			if (got.lvl !== want.lvl || got.unloaded !== want.unloaded ||
					got.boarded !== want.boarded || got.load_after !== want.load_after ||
					got.heading_up !== want.heading_up)
				report("stop mismatch", want, got);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [7:0]            cfg_data;

	sweep_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int cycle_count;
	int beats_counted;
	int settings_used;

	elevator_sweep_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// long receiver hold-off, counted down here
	always @(negedge clk)
		if (hold_left > 0) hold_left <= hold_left - 1;

	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// handshake signals are stable by the falling edge, so sample there
	always @(negedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_stop(m_axis_tdata);

	task automatic send_beat(input logic [1:0] op, input logic [3:0] fl);
		// each idle cycle is drawn on its own
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, fl};
		s_axis_tuser <= op;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		sb.note_request(op, fl);
		if (op == OP_TICK || ((op == OP_CALL || op == OP_DEST) && fl < sb.active_floors()))
			beats_counted++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_stops.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] floors, input logic [7:0] cap);
		cfg_we <= 1'b1;
		cfg_index <= REG_FLOOR_COUNT;
		cfg_data <= floors;
		@(posedge clk);
		sb.set_reg(REG_FLOOR_COUNT, floors);
		cfg_index <= REG_CAPACITY;
		cfg_data <= cap;
		@(posedge clk);
		sb.set_reg(REG_CAPACITY, cap);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic random_beat();
		int r;
		logic [3:0] fl;
		r = $urandom_range(99);
		if ($urandom_range(9) == 0) fl = 4'($urandom_range(15));
		else fl = 4'($urandom_range(sb.active_floors() - 1));
		if (r < 38) send_beat(OP_CALL, fl);
		else if (r < 68) send_beat(OP_DEST, fl);
		else if (r < 95) send_beat(OP_TICK, 4'($urandom_range(15)));
		else send_beat(OP_UNUSED, 4'($urandom_range(15)));
	endtask

	logic [7:0] floors_tab[8] = '{8'd16, 8'd2, 8'hFF, 8'd5, 8'd0, 8'd16, 8'd9, 8'd14};
	logic [7:0] cap_tab[8]    = '{8'd8, 8'd1, 8'd255, 8'd3, 8'd0, 8'd255, 8'd2, 8'd1};

	initial begin
		int target;
		logic [3:0] pick;
		sb = new();
		cycle_count = 0;
		beats_counted = 0;
		settings_used = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FLOOR_COUNT;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, unused opcode, ignored floor on tick
		set_config(8'd16, 8'd8);
		send_beat(OP_CALL, 4'd0);
		send_beat(OP_CALL, 4'd0);
		send_beat(OP_CALL, 4'd0);
		send_beat(OP_CALL, 4'd15);
		send_beat(OP_DEST, 4'd15);
		send_beat(OP_DEST, 4'd0);
		send_beat(OP_UNUSED, 4'd7);
		send_beat(OP_TICK, 4'd15);
		send_beat(OP_DEST, 4'd1);
		send_beat(OP_DEST, 4'd1);
		send_beat(OP_TICK, 4'd0);
		// capacity zero: nobody boards
		wait_idle();
		set_config(8'd16, 8'd0);
		send_beat(OP_CALL, 4'd2);
		send_beat(OP_TICK, 4'd0);
		// floor count below range acts as two; lift now sits above the top floor
		wait_idle();
		set_config(8'd1, 8'd255);
		send_beat(OP_CALL, 4'd5);
		send_beat(OP_DEST, 4'd9);
		send_beat(OP_CALL, 4'd1);
		send_beat(OP_TICK, 4'd0);
		send_beat(OP_TICK, 4'd0);
		send_beat(OP_TICK, 4'd0);
		send_beat(OP_TICK, 4'd0);
		// floor count above range acts as the maximum
		wait_idle();
		set_config(8'hFF, 8'd1);
		send_beat(OP_DEST, 4'd15);
		send_beat(OP_CALL, 4'd14);
		send_beat(OP_TICK, 4'd0);

		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			set_config(floors_tab[ph], cap_tab[ph]);
			send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 60 : 28) : 0;
			recv_stall_pct = (ph % 4 == 2) ? 60 : ((ph % 4 == 3) ? 28 : 0);
			target = beats_counted + PHASE_BEATS;
			// saturate one floor's waiting or bound count
			if (ph == 2 || ph == 5) begin
				pick = 4'($urandom_range(sb.active_floors() - 1));
				repeat (270) send_beat((ph == 2) ? OP_CALL : OP_DEST, pick);
			end
			while (beats_counted < target) begin
				if (ph == 0 && beats_counted == target - PHASE_BEATS / 2) begin
					hold_left <= 300;
					repeat (60) send_beat(OP_TICK, 4'($urandom_range(15)));
				end
				if (ph == 1 && beats_counted == target - PHASE_BEATS / 2) wait_idle();
				random_beat();
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("covered %0d request beats over %0d floor/capacity settings, %0d stops checked",
			beats_counted, settings_used, sb.stops_checked);
		$display("%0d mismatches, %0d ticks never answered", sb.failures, sb.pending_stops.size());
		if (sb.failures == 0 && sb.pending_stops.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ess_pkg.sv
rtl/ess_ram.sv
rtl/elevator_sweep_scheduler.sv
sim/elevator_sweep_scheduler_test.sv
